// ----- rtl/kbae_pkg.sv -----
// Shared types and constants for the K-line block acknowledge engine.
// No dependencies. Imported by every module of the block.
package kbae_pkg;

  // Block-length ceiling, total bytes including the length byte
  localparam int unsigned MAX_BLOCK   = 64;

  localparam int unsigned MAX_LEN_W   = 7;
  localparam int unsigned TIMEOUT_W   = 10;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned ERRCNT_W    = 16;

  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 7'd64;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  // Input kind codes as they arrive on tuser
  localparam logic [2:0] KIND_LINE     = 3'd0;
  localparam logic [2:0] KIND_TICK     = 3'd1;
  localparam logic [2:0] KIND_HOST     = 3'd2;
  localparam logic [2:0] KIND_BEGIN_RX = 3'd3;
  localparam logic [2:0] KIND_SESSION  = 3'd4;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    OP_LINE,
    OP_TICK,
    OP_HOST,
    OP_BEGIN_RX,
    OP_SESSION,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RX,
    PH_TX,
    PH_ACK
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TIMEOUT,
    ERR_MISMATCH,
    ERR_TOO_LONG
  } err_e;

  // Classified item as it sits in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
    logic       is_fill;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Result word, tx_valid in bit 0
  typedef struct packed {
    logic [1:0] pad;
    logic       session_active;
    logic [7:0] block_number;
    err_e       error_code;
    logic       block_done;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;

endpackage

// ----- rtl/kbae_front.sv -----
// Front stage: accepts input transactions, decodes the kind and registers the item.
// Depends on kbae_pkg.
module kbae_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data[7:0]
  input  logic [2:0]         s_axis_tuser,   // kind[2:0]
  input  logic               s_axis_tlast,
  input  kbae_pkg::q_status_t q_status_i,
  output logic               push_o,
  output kbae_pkg::item_t    item_o
);
  import kbae_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  op_e   op;

  always_comb begin
    unique case (s_axis_tuser)
      KIND_LINE:     op = OP_LINE;
      KIND_TICK:     op = OP_TICK;
      KIND_HOST:     op = OP_HOST;
      KIND_BEGIN_RX: op = OP_BEGIN_RX;
      KIND_SESSION:  op = OP_SESSION;
      default:       op = OP_NOP;
    endcase
  end

  assign push_o        = valid_q && !q_status_i.full;
  assign s_axis_tready = !valid_q || !q_status_i.full;
  assign item_o        = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      valid_d        = 1'b1;
      item_d.op      = op;
      item_d.data    = s_axis_tdata;
      item_d.last    = s_axis_tlast;
      item_d.is_fill = (s_axis_tdata == FILL_BYTE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ----- rtl/kbae_queue.sv -----
// Short item queue between the front stage and the protocol engine.
// Depends on kbae_pkg.
module kbae_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kbae_pkg::item_t     item_i,
  input  logic                pop_i,
  output kbae_pkg::item_t     item_o,
  output kbae_pkg::q_status_t status_o
);
  import kbae_pkg::*;

  item_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]    count_q, count_d;

  assign status_o.full  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/kbae_back.sv -----
// Protocol engine: block phase machine, counters, config registers and result register.
// Depends on kbae_pkg.
module kbae_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kbae_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kbae_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  kbae_pkg::q_status_t           q_status_i,
  input  kbae_pkg::item_t               item_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata
);
  import kbae_pkg::*;

  logic [MAX_LEN_W-1:0] max_len_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  phase_e               phase_q, phase_d;
  logic                 session_q, session_d;
  logic [COUNT_W-1:0]   exp_total_q, exp_total_d;
  logic [COUNT_W-1:0]   seen_q, seen_d;
  logic [7:0]           blk_cnt_q, blk_cnt_d;
  logic [7:0]           await_q, await_d;
  logic [TIMEOUT_W-1:0] silence_q, silence_d;
  logic [ERRCNT_W-1:0]  to_errs_q, to_errs_d;
  logic [ERRCNT_W-1:0]  data_errs_q, data_errs_d;

  logic                 out_valid_q;
  result_t              out_q, res;
  logic [COUNT_W-1:0]   limit;
  logic                 fill;

  function automatic logic [ERRCNT_W-1:0] sat_inc(input logic [ERRCNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign pop_o         = !q_status_i.empty && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign limit = ({2'b00, max_len_q} < COUNT_W'(MAX_BLOCK)) ?
                 {2'b00, max_len_q} : COUNT_W'(MAX_BLOCK);
  // 0xFF is filler unless it is the awaited acknowledge of a sent 0x00
  assign fill  = item_i.is_fill && !(phase_q == PH_ACK && await_q == FILL_BYTE);

  always_comb begin
    phase_d     = phase_q;
    session_d   = session_q;
    exp_total_d = exp_total_q;
    seen_d      = seen_q;
    blk_cnt_d   = blk_cnt_q;
    await_d     = await_q;
    silence_d   = silence_q;
    to_errs_d   = to_errs_q;
    data_errs_d = data_errs_q;
    res         = '0;

    unique case (item_i.op)
      OP_LINE: begin
        if (!fill && phase_q == PH_RX) begin
          silence_d   = '0;
          seen_d      = seen_q + 1'b1;
          res.rx_valid = 1'b1;
          res.rx_byte  = item_i.data;
          if (seen_d == COUNT_W'(1)) begin
            exp_total_d = {1'b0, item_i.data} + 1'b1;
            if (exp_total_d > limit) begin
              res.error_code = ERR_TOO_LONG;
              phase_d        = PH_IDLE;
            end
          end else if (seen_d == COUNT_W'(2) && item_i.data != blk_cnt_q) begin
            res.error_code = ERR_MISMATCH;
            data_errs_d    = sat_inc(data_errs_q);
            session_d      = 1'b0;
            phase_d        = PH_IDLE;
          end
          if (res.error_code == ERR_NONE) begin
            if (seen_d < exp_total_d) begin
              res.tx_valid = 1'b1;
              res.tx_byte  = ~item_i.data;
            end else begin
              res.block_done = 1'b1;
              blk_cnt_d      = blk_cnt_q + 1'b1;
              phase_d        = PH_IDLE;
            end
          end
        end else if (!fill && phase_q == PH_ACK) begin
          silence_d = '0;
          if (item_i.data == await_q) begin
            phase_d = PH_TX;
          end else begin
            res.error_code = ERR_MISMATCH;
            data_errs_d    = sat_inc(data_errs_q);
            session_d      = 1'b0;
            phase_d        = PH_IDLE;
          end
        end
      end
      OP_TICK: begin
        if (phase_q == PH_RX || phase_q == PH_ACK) begin
          if (!(&silence_q)) begin
            silence_d = silence_q + 1'b1;
          end
          if (silence_d >= timeout_q) begin
            res.error_code = ERR_TIMEOUT;
            to_errs_d      = sat_inc(to_errs_q);
            session_d      = 1'b0;
            phase_d        = PH_IDLE;
          end
        end
      end
      OP_HOST: begin
        if (phase_q == PH_IDLE || phase_q == PH_TX) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = item_i.data;
          if (item_i.last) begin
            res.block_done = 1'b1;
            blk_cnt_d      = blk_cnt_q + 1'b1;
            phase_d        = PH_IDLE;
          end else begin
            await_d   = ~item_i.data;
            silence_d = '0;
            phase_d   = PH_ACK;
          end
        end
      end
      OP_BEGIN_RX: begin
        phase_d     = PH_RX;
        seen_d      = '0;
        exp_total_d = '0;
        silence_d   = '0;
      end
      OP_SESSION: begin
        session_d   = 1'b1;
        blk_cnt_d   = '0;
        phase_d     = PH_IDLE;
        seen_d      = '0;
        exp_total_d = '0;
        silence_d   = '0;
      end
      default: ;
    endcase

    res.block_number   = blk_cnt_d;
    res.session_active = session_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LEN: max_len_q <= cfg_wdata_i[MAX_LEN_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      session_q   <= 1'b0;
      exp_total_q <= '0;
      seen_q      <= '0;
      blk_cnt_q   <= '0;
      await_q     <= '0;
      silence_q   <= '0;
      to_errs_q   <= '0;
      data_errs_q <= '0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      session_q   <= session_d;
      exp_total_q <= exp_total_d;
      seen_q      <= seen_d;
      blk_cnt_q   <= blk_cnt_d;
      await_q     <= await_d;
      silence_q   <= silence_d;
      to_errs_q   <= to_errs_d;
      data_errs_q <= data_errs_d;
    end
  end

  // Result register: items that report nothing leave no transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= res.tx_valid || res.rx_valid || res.block_done ||
                     (res.error_code != ERR_NONE);
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

endmodule

// ----- rtl/kline_block_ack_engine_unit.sv -----
// Top level of the K-line block acknowledge engine.
// Depends on kbae_pkg, kbae_front, kbae_queue and kbae_back.

// Byte-level block layer of a K-line diagnostic link. Each input transaction
// carries a kind on s_axis_tuser (line byte, millisecond tick, host byte,
// begin receive, new session), a byte on s_axis_tdata and the end-of-block
// mark on s_axis_tlast. Items that have something to report produce one
// 32-bit result transaction; others produce none. The block sustains one
// item per clock while the output is not stalled: the front register, a
// four-entry queue and the engine's result register each pass one item per
// cycle. An accepted item passes through the front register and the queue
// into the result register, which presents its result. The queue lets input
// keep flowing while the output stalls, until the queue is full.
// Configuration writes (max block length, timeout ticks) must be made while
// the block is idle.
module kline_block_ack_engine_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kbae_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kbae_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // data[7:0]
  input  logic [2:0]                      s_axis_tuser,   // kind[2:0]
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tx_valid[0], tx_byte[8:1], rx_valid[9], rx_byte[17:10], block_done[18],
  // error_code[20:19], block_number[28:21], session_active[29], zero[31:30]
  output logic [31:0]                     m_axis_tdata
);
  import kbae_pkg::*;

  q_status_t q_status;
  item_t     push_item, pop_item;
  logic      push, pop;

  kbae_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (push_item)
  );

  kbae_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  kbae_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .q_status_i (q_status),
    .item_i     (pop_item),
    .pop_o      (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

endmodule
